@@ rtl/b64_pkg.sv @@
// Base64 codec package: alphabet functions, register indexes and shared constants.
`timescale 1ns / 1ps
`default_nettype none

package b64_pkg;

  // Most words one input word can cause: four characters and a newline
  localparam int unsigned RES_MAX = 5;
  localparam int unsigned RES_CW  = $clog2(RES_MAX + 1);

  // APB register map: byte address bits and register data width
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [7:0] CHAR_PAD  = 8'h3D;  // '='
  localparam logic [7:0] CHAR_NL   = 8'h0A;  // newline
  localparam logic [7:0] WRAP_RST  = 8'd76;
  localparam logic [5:0] SYM_MASK  = 6'h3F;

  typedef enum logic [1:0] {
    REG_DECODE_MODE  = 2'd0,
    REG_WRAP_COLUMNS = 2'd1,
    REG_SKIP_INVALID = 2'd2
  } reg_idx_t;

  // Decoded symbol: valid flag and its 6-bit value
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sym_t;

  // Map a 6-bit value to its character of the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = 8'h2B;
    else                c = 8'h2F;
    return c;
  endfunction

  // Map a character back to its 6-bit value; valid is low off the alphabet
  function automatic sym_t b64_sym(input logic [7:0] c);
    sym_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A)      s.value = 6'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) s.value = 6'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) s.value = 6'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B)               s.value = 6'd62;
    else if (c == 8'h2F)               s.value = SYM_MASK;
    else                               s.valid = 1'b0;
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/base64_stream_codec.sv @@
// Base64 stream codec top level: input register, codec step, result buffer, APB registers.
// An accepted word is held in the input register until the result buffer is free.
// Throughput: one input word per cycle while each word yields at most one result
//   and out_tready is high; a word with N results (up to five in encode) holds the buffer
//   until all N drain. Sustained rate is set by the one-word-per-cycle drain while ready.
// Reset: synchronous on rst_n low; registers return to decode_mode 0, wrap 76,
//   skip 0; all codec state, the input valid flag and the result count and flag are cleared.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_codec (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_tvalid,
  output      logic                      in_tready,
  input  wire logic [7:0]                in_tdata,   // [7:0] data_byte
  input  wire logic                      in_tlast,   // end_of_stream
  // result channel
  output      logic                      out_tvalid,
  input  wire logic                      out_tready,
  output      logic [7:0]                out_tdata,  // [7:0] out_byte
  output      logic                      out_tlast,  // last_of_run
  output      logic                      out_tuser,  // [0] error_flag
  // configuration port
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [b64_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [b64_pkg::CFG_DW-1:0] cfg_pwdata,
  output      logic [b64_pkg::CFG_DW-1:0] cfg_prdata,
  output      logic                      cfg_pready
);
  import b64_pkg::*;

  // configuration registers
  logic       decode_mode_r;
  logic [7:0] wrap_columns_r;
  logic       skip_invalid_r;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;

  // codec state
  logic [15:0] grp_bytes_r, grp_bytes_nxt;
  logic [1:0]  grp_cnt_r, grp_cnt_nxt;
  logic [8:0]  col_cnt_r, col_cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic        pad_seen_r, pad_seen_nxt;
  logic        err_seen_r, err_seen_nxt;

  // result buffer, drained from entry 0
  logic [7:0]        buf_r [RES_MAX];
  logic [7:0]        buf_nxt [RES_MAX];
  logic [RES_CW-1:0] buf_cnt_r, buf_cnt_nxt;
  logic              buf_err_r, buf_err_nxt;

  // step results
  logic [7:0]        res_bytes [RES_MAX];
  logic [RES_CW-1:0] res_cnt;
  logic              res_err;

  logic out_take, buf_free, proc, in_take, cfg_wr;

  // encode datapath
  logic [23:0] grp_val;
  logic        enc_emit, nl_grp, nl_eos;
  logic [9:0]  col_sum;
  logic [8:0]  col_sat, col_after, col_fin;

  // decode datapath
  sym_t        sym;
  logic [11:0] acc_new;
  logic [3:0]  bit_sum;
  logic [2:0]  bit_new;
  logic [11:0] acc_shift;

  // ---------------------------------------------------------------- handshake
  assign out_tvalid = (buf_cnt_r != '0);
  assign out_tdata  = buf_r[0];
  assign out_tlast  = (buf_cnt_r == RES_CW'(1));
  assign out_tuser  = buf_err_r;
  assign out_take   = out_tvalid && out_tready;
  assign buf_free   = (buf_cnt_r == '0) || (out_tlast && out_tready);
  assign proc       = in_vld_r && buf_free;
  assign in_tready  = !in_vld_r || proc;
  assign in_take    = in_tvalid && in_tready;

  // hold the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  // ---------------------------------------------------------------- encode path
  always_comb begin
    unique case (grp_cnt_r)
      2'd1:    grp_val = {grp_bytes_r[15:8], in_byte_r, 8'h00};
      2'd2:    grp_val = {grp_bytes_r, in_byte_r};
      default: grp_val = {in_byte_r, 16'h0000};
    endcase
    enc_emit  = (grp_cnt_r == 2'd2) || in_eos_r;
    col_sum   = {1'b0, col_cnt_r} + 10'd4;
    col_sat   = col_sum[9] ? 9'h1FF : col_sum[8:0];
    nl_grp    = (wrap_columns_r != 8'd0) && (col_sat >= {1'b0, wrap_columns_r});
    col_after = nl_grp ? 9'd0 : col_sat;
    col_fin   = enc_emit ? col_after : col_cnt_r;
    nl_eos    = in_eos_r && (wrap_columns_r != 8'd0) && (col_fin != 9'd0);
  end

  // ---------------------------------------------------------------- decode path
  always_comb begin
    sym       = b64_sym(in_byte_r);
    acc_new   = {acc_r[5:0], sym.value};
    bit_sum   = {1'b0, bit_cnt_r} + 4'd6;
    bit_new   = bit_sum[3] ? 3'(bit_sum - 4'd8) : bit_sum[2:0];
    acc_shift = acc_new >> bit_new;
  end

  // ---------------------------------------------------------------- step
  always_comb begin
    grp_bytes_nxt = grp_bytes_r;
    grp_cnt_nxt   = grp_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    acc_nxt       = acc_r;
    bit_cnt_nxt   = bit_cnt_r;
    pad_seen_nxt  = pad_seen_r;
    err_seen_nxt  = err_seen_r;
    for (int i = 0; i < RES_MAX; i++) res_bytes[i] = CHAR_NL;
    res_cnt = '0;
    res_err = 1'b0;

    if (!decode_mode_r) begin
      // collect bytes; emit a group when full or at end of stream
      unique case (grp_cnt_r)
        2'd0: begin
          grp_bytes_nxt = {in_byte_r, 8'h00};
          grp_cnt_nxt   = 2'd1;
        end
        2'd1: begin
          grp_bytes_nxt = {grp_bytes_r[15:8], in_byte_r};
          grp_cnt_nxt   = 2'd2;
        end
        default: begin
          grp_bytes_nxt = 16'h0000;
          grp_cnt_nxt   = 2'd0;
        end
      endcase
      if (enc_emit) begin
        res_bytes[0] = b64_char(grp_val[23:18]);
        res_bytes[1] = b64_char(grp_val[17:12]);
        res_bytes[2] = (grp_cnt_r != 2'd0) ? b64_char(grp_val[11:6]) : CHAR_PAD;
        res_bytes[3] = (grp_cnt_r == 2'd2) ? b64_char(grp_val[5:0]) : CHAR_PAD;
        res_cnt      = RES_CW'(4) + RES_CW'(nl_grp) + RES_CW'(nl_eos);
        col_cnt_nxt  = col_after;
      end
    end else if (!pad_seen_r && !err_seen_r) begin
      priority if (in_byte_r == CHAR_PAD) begin
        pad_seen_nxt = 1'b1;
      end else if (!sym.valid) begin
        // unless skipping, flag a bad character once, then drop until end of stream
        if (!skip_invalid_r) begin
          err_seen_nxt = 1'b1;
          res_bytes[0] = 8'h00;
          res_cnt      = RES_CW'(1);
          res_err      = 1'b1;
        end
      end else begin
        acc_nxt     = acc_new;
        bit_cnt_nxt = bit_new;
        if (bit_sum[3]) begin
          res_bytes[0] = acc_shift[7:0];
          res_cnt      = RES_CW'(1);
        end
      end
    end

    // end of stream drops all codec state
    if (in_eos_r) begin
      grp_bytes_nxt = '0;
      grp_cnt_nxt   = '0;
      col_cnt_nxt   = '0;
      acc_nxt       = '0;
      bit_cnt_nxt   = '0;
      pad_seen_nxt  = 1'b0;
      err_seen_nxt  = 1'b0;
    end
  end

  // advance codec state when the step completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_bytes_r <= '0;
      grp_cnt_r   <= '0;
      col_cnt_r   <= '0;
      acc_r       <= '0;
      bit_cnt_r   <= '0;
      pad_seen_r  <= 1'b0;
      err_seen_r  <= 1'b0;
    end else if (proc) begin
      grp_bytes_r <= grp_bytes_nxt;
      grp_cnt_r   <= grp_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      acc_r       <= acc_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      pad_seen_r  <= pad_seen_nxt;
      err_seen_r  <= err_seen_nxt;
    end
  end

  // ---------------------------------------------------------------- result buffer
  always_comb begin
    for (int i = 0; i < RES_MAX - 1; i++) buf_nxt[i] = buf_r[i + 1];
    buf_nxt[RES_MAX-1] = buf_r[RES_MAX-1];
    buf_cnt_nxt = buf_cnt_r;
    buf_err_nxt = buf_err_r;
    if (out_take) buf_cnt_nxt = buf_cnt_r - RES_CW'(1);
    // load a fresh run of words once the previous run has drained
    if (proc && (res_cnt != '0)) begin
      for (int i = 0; i < RES_MAX; i++) buf_nxt[i] = res_bytes[i];
      buf_cnt_nxt = res_cnt;
      buf_err_nxt = res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
      buf_err_r <= 1'b0;
    end else begin
      buf_cnt_r <= buf_cnt_nxt;
      buf_err_r <= buf_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || proc) begin
      for (int i = 0; i < RES_MAX; i++) buf_r[i] <= buf_nxt[i];
    end
  end

  // ---------------------------------------------------------------- APB registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r  <= 1'b0;
      wrap_columns_r <= WRAP_RST;
      skip_invalid_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[3:2]))
        REG_DECODE_MODE:  decode_mode_r  <= cfg_pwdata[0];
        REG_WRAP_COLUMNS: wrap_columns_r <= cfg_pwdata[7:0];
        REG_SKIP_INVALID: skip_invalid_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[3:2]))
      REG_DECODE_MODE:  cfg_prdata = {{(CFG_DW-1){1'b0}}, decode_mode_r};
      REG_WRAP_COLUMNS: cfg_prdata = {{(CFG_DW-8){1'b0}}, wrap_columns_r};
      REG_SKIP_INVALID: cfg_prdata = {{(CFG_DW-1){1'b0}}, skip_invalid_r};
      default:          cfg_prdata = '0;
    endcase
  end

`ifndef SYNTH
  // a run never exceeds the buffer depth
  a_buf_depth: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= RES_CW'(RES_MAX))
    else $error("result buffer count out of range");

  // an error word always stands alone in its run
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error word not last of its run");

  // a stalled run keeps its length
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(buf_cnt_r))
    else $error("result run changed while stalled");

  // decode holds an even number of leftover bits
  a_bits_even: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r[0] == 1'b0)
    else $error("odd decode bit count");
`endif

endmodule

`default_nettype wire

@@ tb/tb_base64_stream_codec.sv @@
// Self-checking testbench for the Base64 stream codec: stream stimulus, predictor, checker.
`timescale 1ns / 1ps

module tb_base64_stream_codec;
  import b64_pkg::*;

  localparam string ALPHA =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } out_word_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] data_byte
  logic                in_tlast;   // end_of_stream
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [7:0] out_byte
  logic                out_tlast;  // last_of_run
  logic                out_tuser;  // [0] error_flag
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Codec registers and state as predicted
  logic       mode_dec;
  logic [7:0] wrap_set;
  logic       skip_bad;
  logic [15:0] grp_bytes;
  logic [1:0]  grp_cnt;
  logic [8:0]  col_count;
  logic [11:0] acc;
  int          acc_bits;
  logic        pad_seen;
  logic        err_seen;

  out_word_t run_q[$];     // words caused by the current input word
  out_word_t due_words[$]; // words the block still owes, oldest first

  int fault_cnt;
  int live_items;
  int hold_reqs;
  bit gap_on;
  bit bursts_on;

  base64_stream_codec dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Alphabet position of a character, -1 off the alphabet
  function automatic int sym_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (ALPHA[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h0A;
      2: return 8'h0D;
      3: return 8'h09;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_wrap();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3: return 8'd76;
      default: return 8'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic push_word(input logic [7:0] d, input logic e);
    run_q.push_back('{data: d, last: 1'b0, err: e});
  endtask

  // Emit four characters of a group, padded, then a newline once the line is full
  task automatic emit_group(input logic [23:0] v, input int used);
    push_word(ALPHA[v[23:18]], 1'b0);
    push_word(ALPHA[v[17:12]], 1'b0);
    push_word(used > 2 ? ALPHA[v[11:6]] : CHAR_PAD, 1'b0);
    push_word(used > 3 ? ALPHA[v[5:0]] : CHAR_PAD, 1'b0);
    col_count = (col_count > 9'd507) ? 9'd511 : col_count + 9'd4;
    if (wrap_set != 8'd0 && col_count >= {1'b0, wrap_set}) begin
      push_word(CHAR_NL, 1'b0);
      col_count = '0;
    end
  endtask

  task automatic clear_codec();
    grp_bytes = '0;
    grp_cnt   = '0;
    col_count = '0;
    acc       = '0;
    acc_bits  = 0;
    pad_seen  = 1'b0;
    err_seen  = 1'b0;
  endtask

  // Predict the words one accepted input word causes and queue them
  task automatic codec_step(input logic [7:0] b, input logic eos);
    int sym;
    out_word_t w;
    run_q.delete();
    sym = sym_index(b);
    if (!mode_dec) begin
      live_items++;
      case (grp_cnt)
        2'd0: begin
          grp_bytes = {b, 8'h00};
          grp_cnt   = 2'd1;
        end
        2'd1: begin
          grp_bytes[7:0] = b;
          grp_cnt        = 2'd2;
        end
        default: begin
          emit_group({grp_bytes, b}, 4);
          grp_bytes = '0;
          grp_cnt   = '0;
        end
      endcase
      if (eos) begin
        if (grp_cnt != 2'd0) emit_group({grp_bytes, 8'h00}, int'(grp_cnt) + 1);
        if (wrap_set != 8'd0 && col_count != 9'd0) push_word(CHAR_NL, 1'b0);
      end
    end else if (!pad_seen && !err_seen) begin
      live_items++;
      if (b == CHAR_PAD) begin
        pad_seen = 1'b1;
      end else if (sym < 0) begin
        if (!skip_bad) begin
          err_seen = 1'b1;
          push_word(8'h00, 1'b1);
        end
      end else begin
        acc = {acc[5:0], 6'(sym)};
        acc_bits += 6;
        if (acc_bits >= 8) begin
          acc_bits -= 8;
          push_word(8'(acc >> acc_bits), 1'b0);
        end
      end
    end
    if (eos) clear_codec();
    if (run_q.size() > 0) begin
      w = run_q.pop_back();
      w.last = 1'b1;
      run_q.push_back(w);
    end
    foreach (run_q[i]) due_words.push_back(run_q[i]);
  endtask

  // Offer one word, with an optional idle burst before it; return at a falling edge
  task automatic send_word(input logic [7:0] b, input logic eos);
    if (gap_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    codec_step(b, eos);
    @(negedge clk);
  endtask

  // Stop offering and wait until every owed word has come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Write one register once the block is idle, then read it back
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
    logic [CFG_DW-1:0] got;
    wait_drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    case (idx)
      REG_DECODE_MODE:  mode_dec = val[0];
      REG_WRAP_COLUMNS: wrap_set = val[7:0];
      REG_SKIP_INVALID: skip_bad = val[0];
      default: ;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== val) begin
      fault_cnt++;
      $error("prdata: expected %h, got %h", val, got);
    end
  endtask

  // Full groups, short groups with one and two pad characters, reset settings
  task automatic test_encode_groups();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b1);
    send_word(8'h01, 1'b0);
    send_word(8'hFE, 1'b1);
  endtask

  // Line wrapping: disabled, lowered mid-line, widest and narrowest
  task automatic test_wrap_midline();
    cfg_write(REG_WRAP_COLUMNS, 32'd0);
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b0);
    send_word(8'h56, 1'b0);
    cfg_write(REG_WRAP_COLUMNS, 32'd4);
    send_word(8'hAA, 1'b0);
    send_word(8'hBB, 1'b0);
    send_word(8'hCC, 1'b1);
    cfg_write(REG_WRAP_COLUMNS, 32'd255);
    send_word(8'h5A, 1'b0);
    send_word(8'hA5, 1'b1);
    cfg_write(REG_WRAP_COLUMNS, 32'd1);
    send_word(8'hC3, 1'b1);
  endtask

  // Decoding: pad ends the text, invalid characters error or get skipped
  task automatic test_decode_text();
    cfg_write(REG_DECODE_MODE, 32'd1);
    cfg_write(REG_SKIP_INVALID, 32'd0);
    send_word("/", 1'b0);
    send_word("+", 1'b0);
    send_word("9", 1'b0);
    send_word("0", 1'b0);
    send_word(CHAR_PAD, 1'b0);
    send_word("A", 1'b1);
    send_word("Q", 1'b0);
    send_word("~", 1'b0);
    send_word("Q", 1'b1);
    cfg_write(REG_SKIP_INVALID, 32'd1);
    send_word(8'h20, 1'b0);
    send_word("w", 1'b0);
    send_word("w", 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  // Encode keeps its partial group across a detour into decode mode
  task automatic test_mode_switch();
    cfg_write(REG_DECODE_MODE, 32'd0);
    cfg_write(REG_WRAP_COLUMNS, 32'd76);
    send_word(8'h41, 1'b0);
    send_word(8'h42, 1'b0);
    cfg_write(REG_DECODE_MODE, 32'd1);
    send_word("Q", 1'b0);
    send_word("Q", 1'b0);
    cfg_write(REG_DECODE_MODE, 32'd0);
    send_word(8'h43, 1'b1);
  endtask

  // Hold the result side off while words keep coming, then pause until drained
  task automatic test_output_hold();
    cfg_write(REG_DECODE_MODE, 32'd0);
    cfg_write(REG_WRAP_COLUMNS, 32'd8);
    gap_on    = 1'b0;
    bursts_on = 1'b0;
    hold_reqs++;
    for (int i = 0; i < 60; i++) send_word(8'($urandom_range(0, 255)), i == 59);
    wait_drain();
    gap_on    = 1'b1;
    bursts_on = 1'b1;
  endtask

  task automatic send_byte_stream();
    int len;
    bit tail;
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 12);
    tail = ($urandom_range(0, 6) != 0);
    for (int i = 0; i < len; i++) send_word(8'($urandom_range(0, 255)), tail && i == len - 1);
  endtask

  // Mostly alphabet text with optional padding; noise is rarer when it would error
  task automatic send_text_stream();
    logic [7:0] txt[$];
    int len;
    int junk_pct;
    junk_pct = skip_bad ? 12 : 2;
    len = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < junk_pct) txt.push_back(noise_char());
      else txt.push_back(ALPHA[$urandom_range(0, 63)]);
    end
    case ($urandom_range(0, 3))
      1: txt.push_back(CHAR_PAD);
      2: begin
        txt.push_back(CHAR_PAD);
        txt.push_back(CHAR_PAD);
      end
      3: begin
        txt.push_back(CHAR_PAD);
        txt.push_back(ALPHA[$urandom_range(0, 63)]);
      end
      default: ;
    endcase
    foreach (txt[i]) send_word(txt[i], i == txt.size() - 1);
  endtask

  // Random settings per phase, a few streams each, until enough live words went in
  task automatic test_random_streams(input int goal, input bit with_idle);
    int stop_at;
    stop_at = live_items + goal;
    while (live_items < stop_at) begin
      cfg_write(REG_DECODE_MODE, 32'($urandom_range(0, 1)));
      cfg_write(REG_WRAP_COLUMNS, {24'd0, pick_wrap()});
      cfg_write(REG_SKIP_INVALID, 32'($urandom_range(0, 1)));
      gap_on    = with_idle && ($urandom_range(0, 3) != 0);
      bursts_on = with_idle && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) begin
        if (mode_dec) send_text_stream();
        else send_byte_stream();
      end
    end
    wait_drain();
  endtask

  // Drive the result side's ready: long hold on request, random stall bursts
  initial begin : drain_side
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest owed word
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_words.size() == 0) begin
        fault_cnt++;
        $error("out_byte: no word expected, got %h", out_tdata);
      end else begin
        want = due_words.pop_front();
        if (out_tdata !== want.data) begin
          fault_cnt++;
          $error("out_byte: expected %h, got %h", want.data, out_tdata);
        end
        if (out_tlast !== want.last) begin
          fault_cnt++;
          $error("last_of_run: expected %b, got %b", want.last, out_tlast);
        end
        if (out_tuser !== want.err) begin
          fault_cnt++;
          $error("error_flag: expected %b, got %b", want.err, out_tuser);
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run
    fault_cnt   = 0;
    live_items  = 0;
    hold_reqs   = 0;
    gap_on      = 1'b1;
    bursts_on   = 1'b1;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mode_dec    = 1'b0;
    wrap_set    = WRAP_RST;
    skip_bad    = 1'b0;
    clear_codec();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_encode_groups();
    test_wrap_midline();
    test_decode_text();
    test_mode_switch();
    test_output_hold();
    test_random_streams(300, 1'b1);
    // last stretch runs without any idling on either side
    test_random_streams(30, 1'b0);

    wait_drain();
    repeat (10) @(negedge clk);
    if (fault_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
